### hw/rtl/frame_index_to_ltc_timecode_top_defines.svh
// assertion macros for the frame index to ltc timecode block
// used by frame_index_to_ltc_timecode_top; expects clk and rst_n in the including scope
`ifndef FRAME_INDEX_TO_LTC_TIMECODE_TOP_DEFINES_SVH
`define FRAME_INDEX_TO_LTC_TIMECODE_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LTCTC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ltc timecode check failed");

// next-cycle implication, disabled during reset
`define LTCTC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ltc timecode check failed");

`endif

### hw/rtl/ltctc_pkg.sv
// shared types, constants and helpers for the ltc timecode converter
// no dependencies; used by the cfg and frame interfaces, the top level and the checker
package ltctc_pkg;

    localparam int FRAME_INDEX_W = 32;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 6;
    localparam int RATE_W        = 5;
    localparam int SEC_W         = 6;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FPS  = 2'd0,
        CFG_DROP = 2'd1,
        CFG_LTC  = 2'd2
    } cfg_reg_t;

    localparam logic [5:0] FPS_RESET       = 6'd25;
    localparam logic [5:0] FPS_HALVE_ABOVE = 6'd30;
    localparam logic [5:0] FPS_GROUP_LO    = 6'd25;
    localparam logic [5:0] FPS_GROUP_HI    = 6'd50;
    localparam logic [5:0] SEC_PER_MIN     = 6'd60;
    localparam logic [RATE_W-1:0] RATE_GROUP = 5'd25;

    // tens and units of a value below 64
    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] units;
    } bcd_t;

    // sideband carried through the second and third dividers
    typedef struct packed {
        logic              f2;
        logic [RATE_W-1:0] frames;
    } side2_t;

    typedef struct packed {
        logic              f2;
        logic [RATE_W-1:0] frames;
        logic [SEC_W-1:0]  secs;
    } side3_t;

    // one timecode result
    typedef struct packed {
        logic [3:0] frame_units;
        logic [1:0] frame_tens;
        logic [3:0] second_units;
        logic [2:0] second_tens;
        logic [3:0] minute_units;
        logic [2:0] minute_tens;
        logic [3:0] hour_units;
        logic [1:0] hour_tens;
        logic       drop_flag;
        logic       field_mark;
        logic       group_flag_bit;
        logic       hours_overflow;
    } result_t;

    // split a value below 64 into decimal digits, x/10 as (x*205)>>11
    function automatic bcd_t bcd_split(input logic [5:0] x);
        logic [13:0] prod;
        logic [2:0]  q;
        logic [5:0]  q10;
        logic [5:0]  diff;
        bcd_t        r;
        prod    = 14'(x) * 14'd205;
        q       = prod[13:11];
        q10     = {q, 3'b000} + {2'b00, q, 1'b0};
        diff    = x - q10;
        r.tens  = q;
        r.units = diff[3:0];
        return r;
    endfunction

endpackage

### hw/rtl/ltctc_in_if.sv
// frame index input channel: valid/ready handshake with index and field mark
// depends on ltctc_pkg
interface ltctc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [ltctc_pkg::FRAME_INDEX_W-1:0]  frame_index;
    logic                                 second_field;

    modport source (output valid, output frame_index, output second_field, input ready);
    modport sink   (input valid, input frame_index, input second_field, output ready);
endinterface

### hw/rtl/ltctc_out_if.sv
// timecode result channel: valid/ready handshake with bcd digits and flag bits
// no package dependency
interface ltctc_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] frame_units;
    logic [1:0] frame_tens;
    logic [3:0] second_units;
    logic [2:0] second_tens;
    logic [3:0] minute_units;
    logic [2:0] minute_tens;
    logic [3:0] hour_units;
    logic [1:0] hour_tens;
    logic       drop_flag;
    logic       field_mark;
    logic       group_flag_bit;
    logic       hours_overflow;

    modport source (
        output valid, output frame_units, output frame_tens, output second_units,
        output second_tens, output minute_units, output minute_tens, output hour_units,
        output hour_tens, output drop_flag, output field_mark, output group_flag_bit,
        output hours_overflow, input ready
    );
    modport sink (
        input valid, input frame_units, input frame_tens, input second_units,
        input second_tens, input minute_units, input minute_tens, input hour_units,
        input hour_tens, input drop_flag, input field_mark, input group_flag_bit,
        input hours_overflow, output ready
    );
endinterface

### hw/rtl/ltctc_cfg_if.sv
// configuration write channel: valid/ready handshake with register index and data
// depends on ltctc_pkg
interface ltctc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ltctc_pkg::CFG_INDEX_W-1:0]  index;
    logic [ltctc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/ltctc_div.sv
// pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels with each transaction; no package dependency
module ltctc_div #(
    parameter int DW = 32,
    parameter int VW = 5,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder,
    output logic [SW-1:0] out_side
);

    // per stage: work holds remaining dividend bits on top, quotient bits below
    logic          valid_reg [DW];
    logic [DW-1:0] work_reg  [DW];
    logic [VW-1:0] rem_reg   [DW];
    logic [SW-1:0] side_reg  [DW];

    logic          valid_next [DW];
    logic [DW-1:0] work_next  [DW];
    logic [VW-1:0] rem_next   [DW];
    logic [SW-1:0] side_next  [DW];

    // one compare and subtract per stage
    always_comb
    begin : p_stage_next
        logic          v;
        logic [DW-1:0] w;
        logic [VW-1:0] r;
        logic [SW-1:0] sd;
        logic [VW:0]   trial;
        logic          fits;
        for (int s = 0; s < DW; s++)
        begin
            if (s == 0)
            begin
                v  = in_valid;
                w  = dividend;
                r  = '0;
                sd = in_side;
            end
            else
            begin
                v  = valid_reg[s-1];
                w  = work_reg[s-1];
                r  = rem_reg[s-1];
                sd = side_reg[s-1];
            end
            trial         = {r, w[DW-1]};
            fits          = (trial >= {1'b0, divisor});
            valid_next[s] = v;
            rem_next[s]   = fits ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
            work_next[s]  = {w[DW-2:0], fits};
            side_next[s]  = sd;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DW; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int s = 0; s < DW; s++)
            begin
                valid_reg[s] <= valid_next[s];
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DW; s++)
            begin
                work_reg[s] <= work_next[s];
                rem_reg[s]  <= rem_next[s];
                side_reg[s] <= side_next[s];
            end
        end
    end

    assign out_valid = valid_reg[DW-1];
    assign quotient  = work_reg[DW-1];
    assign remainder = rem_reg[DW-1];
    assign out_side  = side_reg[DW-1];

endmodule

### hw/rtl/frame_index_to_ltc_timecode_top.sv
// frame index to smpte ltc timecode converter, top level
// depends on ltctc_pkg, the three channel interfaces, ltctc_div and the defines header
//
// Usage: frame indexes arrive on the frame channel (valid/ready), one
// timecode transaction leaves on the timecode channel for each of them, in
// order. Configuration registers (frame rate, drop flag, ltc parity) are
// written on the cfg channel, which is always ready; write them only while
// no transaction is in flight.
// Pipeline: an input stage, the bit-per-stage divider by the frame rate
// (INDEX_WIDTH stages), two stages that each divide by 60 through a shift
// and a reciprocal multiply, a digit stage and the output register.
// Throughput: one transaction per cycle while the receiver holds ready high.
// Reset: clears all valid bits and loads 25 fps, drop flag and parity off.
// Stall: when the receiver holds ready low, a skid register takes the next
// result and the whole pipeline then holds; frame.ready drops only while
// the skid register is full, so nothing is lost or repeated.
`include "frame_index_to_ltc_timecode_top_defines.svh"

module frame_index_to_ltc_timecode_top #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    ltctc_cfg_if.sink    cfg,
    ltctc_in_if.sink     frame,
    ltctc_out_if.source  timecode
);

    localparam int IW = INDEX_WIDTH;
    localparam int HW = INDEX_WIDTH - 5;
    localparam int K  = HW + 3;
    localparam longint unsigned RECIP = ((64'd1 << K) + 64'd9) / 64'd10;
    localparam int K1 = IW + 2;
    localparam int K2 = HW + 2;
    localparam longint unsigned RECIP15_S = ((64'd1 << K1) + 64'd14) / 64'd15;
    localparam longint unsigned RECIP15_M = ((64'd1 << K2) + 64'd14) / 64'd15;
    localparam int RW  = ltctc_pkg::RATE_W;
    localparam int SCW = ltctc_pkg::SEC_W;

    // configuration registers
    logic [5:0] fps_reg;
    logic       drop_reg;
    logic       ltc_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fps_reg  <= ltctc_pkg::FPS_RESET;
            drop_reg <= 1'b0;
            ltc_reg  <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (ltctc_pkg::cfg_reg_t'(cfg.index))
                ltctc_pkg::CFG_FPS:  fps_reg  <= cfg.data;
                ltctc_pkg::CFG_DROP: drop_reg <= cfg.data[0];
                ltctc_pkg::CFG_LTC:  ltc_reg  <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // effective rate: zero counts as one, rates above 30 are halved
    logic [5:0]    rate_raw;
    logic          halve;
    logic [RW-1:0] rate_eff;

    assign rate_raw = (fps_reg == 6'd0) ? 6'd1 : fps_reg;
    assign halve    = (fps_reg > ltctc_pkg::FPS_HALVE_ABOVE);
    assign rate_eff = halve ? rate_raw[5:1] : rate_raw[RW-1:0];

    // pipeline advance, held only while the skid register is full
    logic advance;
    logic skid_valid_reg;

    assign advance     = !skid_valid_reg;
    assign frame.ready = advance;

    // input stage: mask the index and, at rates above 30, halve it
    logic          in_valid_reg;
    logic [IW-1:0] idx_reg;
    logic          f2_reg;
    logic [IW-1:0] idx_w;

    assign idx_w = frame.frame_index[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= frame.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            idx_reg <= halve ? {1'b0, idx_w[IW-1:1]} : idx_w;
            f2_reg  <= frame.second_field;
        end
    end

    // divide by the rate: total seconds and frames
    logic          d1_valid;
    logic [IW-1:0] d1_secs_total;
    logic [RW-1:0] d1_frames;
    logic          d1_f2;

    ltctc_div #(.DW(IW), .VW(RW), .SW(1)) u_div_rate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (in_valid_reg),
        .dividend  (idx_reg),
        .divisor   (rate_eff),
        .in_side   (f2_reg),
        .out_valid (d1_valid),
        .quotient  (d1_secs_total),
        .remainder (d1_frames),
        .out_side  (d1_f2)
    );

    // divide by 60: total minutes as (secs/4) * (1/15), exact for IW-bit inputs
    logic [IW-2:0]         m1_recip;
    logic [2*IW-4:0]       m1_prod;
    logic                  m1_valid_reg;
    logic [HW-1:0]         m1_mins_total_reg;
    logic [SCW-1:0]        m1_secs_lo_reg;
    ltctc_pkg::side2_t     m1_side_reg;
    ltctc_pkg::side2_t     d1_side;

    assign d1_side.f2     = d1_f2;
    assign d1_side.frames = d1_frames;
    assign m1_recip       = (IW-1)'(RECIP15_S);
    assign m1_prod        = (2*IW-3)'(d1_secs_total[IW-1:2]) * (2*IW-3)'(m1_recip);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m1_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m1_mins_total_reg <= m1_prod[2*IW-4:K1];
            m1_secs_lo_reg    <= d1_secs_total[SCW-1:0];
            m1_side_reg       <= d1_side;
        end
    end

    // divide by 60 again: hours; seconds are total - 60*q, i.e. low bits + 4*q mod 64
    logic [HW-2:0]         m2_recip;
    logic [2*HW-4:0]       m2_prod;
    logic [SCW-1:0]        m1_secs;
    logic                  m2_valid_reg;
    logic [HW-6:0]         m2_hours_reg;
    logic [SCW-1:0]        m2_mins_lo_reg;
    ltctc_pkg::side3_t     m2_side_reg;
    ltctc_pkg::side3_t     m1_side3;

    assign m2_recip        = (HW-1)'(RECIP15_M);
    assign m2_prod         = (2*HW-3)'(m1_mins_total_reg[HW-1:2]) * (2*HW-3)'(m2_recip);
    assign m1_secs         = m1_secs_lo_reg + {m1_mins_total_reg[3:0], 2'b00};
    assign m1_side3.f2     = m1_side_reg.f2;
    assign m1_side3.frames = m1_side_reg.frames;
    assign m1_side3.secs   = m1_secs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m2_hours_reg   <= m2_prod[2*HW-4:K2];
            m2_mins_lo_reg <= m1_mins_total_reg[SCW-1:0];
            m2_side_reg    <= m1_side3;
        end
    end

    // hours, minutes and sideband into the digit stage
    logic                  d3_valid;
    logic [HW-1:0]         d3_hours;
    logic [SCW-1:0]        d3_mins;
    ltctc_pkg::side3_t     d3_side;

    assign d3_valid = m2_valid_reg;
    assign d3_hours = {5'b00000, m2_hours_reg};
    assign d3_mins  = m2_mins_lo_reg + {m2_hours_reg[3:0], 2'b00};
    assign d3_side  = m2_side_reg;

    // digit stage: small digits by multiply by 205 and shift, hours/10 by reciprocal multiply
    logic [HW-1:0]     recip;
    logic [2*HW-1:0]   hour_prod;
    logic              a_valid_reg;
    ltctc_pkg::bcd_t   a_fr_reg;
    ltctc_pkg::bcd_t   a_sec_reg;
    ltctc_pkg::bcd_t   a_min_reg;
    logic [3:0]        a_hlo_reg;
    logic [HW-4:0]     a_hq_reg;
    logic              a_f2_reg;

    assign recip     = HW'(RECIP);
    assign hour_prod = (2*HW)'(d3_hours) * (2*HW)'(recip);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= d3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_fr_reg  <= ltctc_pkg::bcd_split({1'b0, d3_side.frames});
            a_sec_reg <= ltctc_pkg::bcd_split(d3_side.secs);
            a_min_reg <= ltctc_pkg::bcd_split(d3_mins);
            a_hlo_reg <= d3_hours[3:0];
            a_hq_reg  <= hour_prod[2*HW-1:K];
            a_f2_reg  <= d3_side.f2;
        end
    end

    // result assembly: hour digits, parity and mark placement
    ltctc_pkg::result_t result;
    logic [3:0]         hq10_lo;
    logic               parity;
    logic               group_rate;

    assign hq10_lo    = {a_hq_reg[0], 3'b000} + {a_hq_reg[2:0], 1'b0};
    assign group_rate = (fps_reg == ltctc_pkg::FPS_GROUP_LO)
                        || (fps_reg == ltctc_pkg::FPS_GROUP_HI);

    always_comb
    begin
        result.frame_units    = a_fr_reg.units;
        result.frame_tens     = a_fr_reg.tens[1:0];
        result.second_units   = a_sec_reg.units;
        result.second_tens    = a_sec_reg.tens;
        result.minute_units   = a_min_reg.units;
        result.minute_tens    = a_min_reg.tens;
        result.hour_units     = a_hlo_reg - hq10_lo;
        result.hour_tens      = a_hq_reg[1:0];
        result.hours_overflow = |a_hq_reg[HW-4:2];
        result.drop_flag      = drop_reg;
        parity = ~(^{result.frame_units, result.frame_tens, result.second_units,
                     result.second_tens, result.minute_units, result.minute_tens,
                     result.hour_units, result.hour_tens, result.drop_flag});
        result.field_mark     = 1'b0;
        result.group_flag_bit = 1'b0;
        if (ltc_reg)
        begin
            if (rate_eff == ltctc_pkg::RATE_GROUP)
            begin
                result.group_flag_bit = parity;
            end
            else
            begin
                result.field_mark = parity;
            end
        end
        else if (a_f2_reg)
        begin
            if (group_rate)
            begin
                result.group_flag_bit = 1'b1;
            end
            else
            begin
                result.field_mark = 1'b1;
            end
        end
    end

    // output register with skid stage
    logic               push;
    logic               pop;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               skid_valid_next;
    ltctc_pkg::result_t out_data_reg;
    ltctc_pkg::result_t out_data_next;
    ltctc_pkg::result_t skid_data_reg;
    ltctc_pkg::result_t skid_data_next;

    assign push = advance && a_valid_reg;
    assign pop  = out_valid_reg && timecode.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            out_valid_next  = skid_valid_reg || push;
            out_data_next   = skid_valid_reg ? skid_data_reg : result;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign timecode.valid          = out_valid_reg;
    assign timecode.frame_units    = out_data_reg.frame_units;
    assign timecode.frame_tens     = out_data_reg.frame_tens;
    assign timecode.second_units   = out_data_reg.second_units;
    assign timecode.second_tens    = out_data_reg.second_tens;
    assign timecode.minute_units   = out_data_reg.minute_units;
    assign timecode.minute_tens    = out_data_reg.minute_tens;
    assign timecode.hour_units     = out_data_reg.hour_units;
    assign timecode.hour_tens      = out_data_reg.hour_tens;
    assign timecode.drop_flag      = out_data_reg.drop_flag;
    assign timecode.field_mark     = out_data_reg.field_mark;
    assign timecode.group_flag_bit = out_data_reg.group_flag_bit;
    assign timecode.hours_overflow = out_data_reg.hours_overflow;

    // checks
    logic stall_push;
    logic digits_ok;

    assign stall_push = out_valid_reg && !timecode.ready && push;
    assign digits_ok  = (timecode.frame_units <= 4'd9) && (timecode.second_units <= 4'd9)
                        && (timecode.minute_units <= 4'd9) && (timecode.hour_units <= 4'd9)
                        && (timecode.second_tens <= 3'd5) && (timecode.minute_tens <= 3'd5);

    `LTCTC_ASSERT_IMP(a_skid_needs_out, skid_valid_reg, out_valid_reg)
    `LTCTC_ASSERT_NXT(a_skid_fills_on_stall, stall_push, skid_valid_reg)
    `LTCTC_ASSERT_IMP(a_digits_bcd, timecode.valid, digits_ok)
    `LTCTC_ASSERT_IMP(a_single_mark, timecode.valid, !(timecode.field_mark && timecode.group_flag_bit))

endmodule

### dv/frame_index_to_ltc_timecode_checker.sv
// self-checking monitor for the frame index to ltc timecode converter
// depends on ltctc_pkg and the cfg, frame and timecode channel interfaces
`timescale 1ns / 100ps

module frame_index_to_ltc_timecode_checker (
    input  logic  clk,
    input  logic  rst_n,
    ltctc_cfg_if  cfg,
    ltctc_in_if   frame,
    ltctc_out_if  timecode,
    output int    mismatches,
    output int    outstanding
);

    localparam int REPORT_LIMIT = 10;

    // shadow copy of the configuration registers
    logic [5:0] rate_setting;
    logic       drop_setting;
    logic       parity_setting;

    // timecodes still owed by the block, oldest first
    ltctc_pkg::result_t pending_timecodes [$];

    // timecode of one frame index under the current settings
    function automatic ltctc_pkg::result_t timecode_of(input logic [31:0] index_in,
                                                       input logic f2);
        logic [31:0] index;
        int unsigned rate;
        int unsigned hours;
        int unsigned remainder;
        int unsigned mins;
        int unsigned secs;
        int unsigned frames;
        logic        parity;
        ltctc_pkg::result_t tc;
        tc    = '0;
        index = index_in;
        rate  = (rate_setting == 6'd0) ? 1 : int'(rate_setting);
        // field two mark uses the rate as written
        if (f2 && !parity_setting)
        begin
            if (rate == 25 || rate == 50)
                tc.group_flag_bit = 1'b1;
            else
                tc.field_mark = 1'b1;
        end
        // high rates count frame pairs
        if (rate > 30)
        begin
            rate  = rate >> 1;
            index = index >> 1;
        end
        hours     = index / (3600 * rate);
        remainder = index % (3600 * rate);
        mins      = remainder / (60 * rate);
        remainder = remainder % (60 * rate);
        secs      = remainder / rate;
        frames    = remainder % rate;
        tc.frame_units    = 4'(frames % 10);
        tc.frame_tens     = 2'(frames / 10);
        tc.second_units   = 4'(secs % 10);
        tc.second_tens    = 3'(secs / 10);
        tc.minute_units   = 4'(mins % 10);
        tc.minute_tens    = 3'(mins / 10);
        tc.hour_units     = 4'(hours % 10);
        tc.hour_tens      = 2'(hours / 10);
        tc.hours_overflow = (hours >= 40);
        tc.drop_flag      = drop_setting;
        // odd parity over digits and drop flag, placed by the halved rate
        if (parity_setting)
        begin
            parity = ~^{tc.frame_units, tc.frame_tens, tc.second_units, tc.second_tens,
                        tc.minute_units, tc.minute_tens, tc.hour_units, tc.hour_tens,
                        tc.drop_flag};
            if (rate == 25 || rate == 50)
                tc.group_flag_bit = parity;
            else
                tc.field_mark = parity;
        end
        return tc;
    endfunction

    function automatic string timecode_text(input ltctc_pkg::result_t tc);
        return $sformatf("%0d%0d:%0d%0d:%0d%0d:%0d%0d drop %0d field %0d group %0d ovf %0d",
                         tc.hour_tens, tc.hour_units, tc.minute_tens, tc.minute_units,
                         tc.second_tens, tc.second_units, tc.frame_tens, tc.frame_units,
                         tc.drop_flag, tc.field_mark, tc.group_flag_bit, tc.hours_overflow);
    endfunction

    // watch all three channels
    always @(posedge clk or negedge rst_n)
    begin
        ltctc_pkg::result_t observed;
        ltctc_pkg::result_t predicted;
        if (!rst_n)
        begin
            rate_setting   = ltctc_pkg::FPS_RESET;
            drop_setting   = 1'b0;
            parity_setting = 1'b0;
            pending_timecodes.delete();
            mismatches     = 0;
            outstanding    = 0;
        end
        else
        begin
            // register write transaction
            if (cfg.valid && cfg.ready)
            begin
                case (ltctc_pkg::cfg_reg_t'(cfg.index))
                    ltctc_pkg::CFG_FPS:  rate_setting   = cfg.data;
                    ltctc_pkg::CFG_DROP: drop_setting   = cfg.data[0];
                    ltctc_pkg::CFG_LTC:  parity_setting = cfg.data[0];
                    default:  ;
                endcase
            end
            // frame transaction
            if (frame.valid && frame.ready)
                pending_timecodes.push_back(timecode_of(frame.frame_index, frame.second_field));
            // timecode transaction
            if (timecode.valid && timecode.ready)
            begin
                observed.frame_units    = timecode.frame_units;
                observed.frame_tens     = timecode.frame_tens;
                observed.second_units   = timecode.second_units;
                observed.second_tens    = timecode.second_tens;
                observed.minute_units   = timecode.minute_units;
                observed.minute_tens    = timecode.minute_tens;
                observed.hour_units     = timecode.hour_units;
                observed.hour_tens      = timecode.hour_tens;
                observed.drop_flag      = timecode.drop_flag;
                observed.field_mark     = timecode.field_mark;
                observed.group_flag_bit = timecode.group_flag_bit;
                observed.hours_overflow = timecode.hours_overflow;
                if (pending_timecodes.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: unexpected timecode %s", $realtime,
                                 timecode_text(observed));
                    mismatches++;
                end
                else
                begin
                    predicted = pending_timecodes.pop_front();
                    if (observed !== predicted)
                    begin
                        if (mismatches < REPORT_LIMIT)
                        begin
                            $display("%0t: timecode mismatch", $realtime);
                            $display("    expected %s", timecode_text(predicted));
                            $display("    actual   %s", timecode_text(observed));
                        end
                        mismatches++;
                    end
                end
            end
            outstanding = pending_timecodes.size();
        end
    end

endmodule

### dv/tb_frame_index_to_ltc_timecode_top.sv
// stimulus and verdict for frame_index_to_ltc_timecode_top
// depends on ltctc_pkg, the channel interfaces, the block and the timecode checker
`timescale 1ns / 100ps

module tb_frame_index_to_ltc_timecode_top;

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int DRAIN_CYCLES    = 100;

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   mismatches;
    int   outstanding;

    ltctc_cfg_if cfg_bus ();
    ltctc_in_if  frame_bus ();
    ltctc_out_if timecode_bus ();

    frame_index_to_ltc_timecode_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_bus),
        .frame    (frame_bus),
        .timecode (timecode_bus)
    );

    frame_index_to_ltc_timecode_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_bus),
        .frame       (frame_bus),
        .timecode    (timecode_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver back-pressure
    initial
        timecode_bus.ready = 1'b0;

    always @(posedge clk)
        timecode_bus.ready <= ($urandom_range(99) >= stall_pct);

    // overall time limit
    initial
    begin
        #2000000;
        $display("frame_index_to_ltc_timecode_top regression: fail");
        $finish;
    end

    // one frame transaction, with random idle cycles ahead of it
    task automatic send_frame(input logic [31:0] index, input logic f2);
        if ($urandom_range(99) < idle_pct)
        begin
            frame_bus.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        frame_bus.valid        <= 1'b1;
        frame_bus.frame_index  <= index;
        frame_bus.second_field <= f2;
        do
            @(posedge clk);
        while (!frame_bus.ready);
    endtask

    // all three registers, written once the pipeline is empty
    task automatic write_settings(input logic [5:0] fps, input logic drop, input logic ltc);
        frame_bus.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= ltctc_pkg::CFG_FPS;
        cfg_bus.data  <= fps;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.index <= ltctc_pkg::CFG_DROP;
        cfg_bus.data  <= ltctc_pkg::CFG_DATA_W'(drop);
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.index <= ltctc_pkg::CFG_LTC;
        cfg_bus.data  <= ltctc_pkg::CFG_DATA_W'(ltc);
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    // main sequence
    initial
    begin
        logic [5:0]  phase_fps [PHASES];
        logic [31:0] index;
        logic [31:0] next_index;
        int unsigned rate;
        int unsigned step;
        int unsigned per_hour;
        int          phase;
        int          n;
        phase_fps = '{6'd25, 6'd30, 6'd24, 6'd50, 6'd60, 6'd1,
                      6'd0, 6'd63, 6'd29, 6'd31, 6'd51, 6'd61};
        idle_pct               = 0;
        stall_pct              = 0;
        rst_n                  = 1'b0;
        frame_bus.valid        = 1'b0;
        frame_bus.frame_index  = '0;
        frame_bus.second_field = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = ltctc_pkg::CFG_FPS;
        cfg_bus.data           = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, digit rollovers and field extremes
        send_frame(32'd0, 1'b0);
        send_frame(32'd24, 1'b1);
        send_frame(32'd25, 1'b0);
        send_frame(32'd1499, 1'b1);
        send_frame(32'd1500, 1'b0);
        send_frame(32'd89999, 1'b1);
        send_frame(32'd90000, 1'b0);
        send_frame(32'd3599999, 1'b1);
        send_frame(32'd3600000, 1'b0);
        send_frame(32'hFFFF_FFFF, 1'b1);
        send_frame(32'h5555_5555, 1'b0);
        send_frame(32'hAAAA_AAAA, 1'b1);
        // zero rate with parity and drop flag
        write_settings(6'd0, 1'b1, 1'b1);
        send_frame(32'd0, 1'b1);
        send_frame(32'd3599, 1'b0);
        send_frame(32'd143999, 1'b1);
        send_frame(32'hFFFF_FFFF, 1'b0);
        // odd high rate landing on the group bit
        write_settings(6'd51, 1'b0, 1'b1);
        send_frame(32'd49, 1'b0);
        send_frame(32'd50, 1'b1);
        send_frame(32'd7200000, 1'b0);
        send_frame(32'hFFFF_FFFE, 1'b1);
        // top of the rate field, field two mark without parity
        write_settings(6'd63, 1'b1, 1'b0);
        send_frame(32'd61, 1'b1);
        send_frame(32'd62, 1'b1);
        send_frame(32'h8000_0000, 1'b1);

        // random phases over rates, flags, idling and back-pressure patterns
        for (phase = 0; phase < PHASES; phase++)
        begin
            write_settings(phase_fps[phase], phase[0], phase[1]);
            case (phase % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 70;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 70;
                end
                default:
                begin
                    idle_pct  = 30;
                    stall_pct = 30;
                end
            endcase
            rate = (phase_fps[phase] == 6'd0) ? 1 : int'(phase_fps[phase]);
            step = (rate > 30) ? 2 : 1;
            if (rate > 30)
                rate = rate >> 1;
            per_hour   = 3600 * rate * step;
            // running count starts just short of an hour boundary
            next_index = per_hour * $urandom_range(1, 45) - $urandom_range(0, 60);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3:
                    begin
                        next_index = next_index + $urandom_range(1, 2);
                        index      = next_index;
                    end
                    4, 5:
                        index = $urandom;
                    6, 7:
                        index = (60 * rate * step) * $urandom_range(0, 3000)
                                + $urandom_range(0, 4) - 2;
                    8:
                        index = per_hour * $urandom_range(38, 42) + $urandom_range(0, 4) - 2;
                    default:
                        index = $urandom_range(0, 24 * per_hour);
                endcase
                send_frame(index, 1'($urandom_range(1)));
            end
        end

        // drain and verdict
        frame_bus.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("frame_index_to_ltc_timecode_top regression: pass");
        else
            $display("frame_index_to_ltc_timecode_top regression: fail");
        $finish;
    end

endmodule
